FILE: hw/rtl/jsv_pkg.sv
// ============================================================================
// JSON string value decoder - shared package
// Result codes, decoder phases, character constants and the bundle type that
// carries the results of one text byte from the front part to the back part.
// ============================================================================
package jsv_pkg;

    // Kind codes of a result word.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_NOTSTR = 2'd2;
    localparam logic [1:0] KIND_UNTERM = 2'd3;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Characters held after \u before they are dropped: the span of the
    // escape (five) less the 'u' and the character that does the drop.
    localparam int         HEX_SPAN  = 5;
    localparam logic [1:0] HOLD_FULL = 2'(HEX_SPAN - 2);
    localparam int         HOLD_MAX  = HEX_SPAN - 2;

    // Most results that one text byte can cause.
    localparam int RES_MAX = 4;

    // Default depth of the bundle queue.
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_TEXT = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HOLD = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [2:0]               cnt;
        res_t [RES_MAX-1:0]       ent;
    } bundle_t;

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CH_LOW_B: r = CH_BS;
            CH_LOW_F: r = CH_FF;
            CH_LOW_N: r = CH_LF;
            CH_LOW_R: r = CH_CR;
            CH_LOW_T: r = CH_TAB;
            CH_LOW_U: r = CH_QMARK;
            default:  r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic res_t mk_res(input logic [7:0] b, input logic [1:0] k,
                                    input logic l);
        res_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = l;
        return r;
    endfunction

endpackage

FILE: hw/rtl/jsv_in_if.sv
// ============================================================================
// JSON string value decoder - text input channel
// Valid/ready channel that carries one text byte and its end-of-text mark.
// ============================================================================
interface jsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: hw/rtl/jsv_out_if.sv
// ============================================================================
// JSON string value decoder - result output channel
// Valid/ready channel that carries one decoded result word.
// ============================================================================
interface jsv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

FILE: hw/rtl/jsv_front.sv
// ============================================================================
// JSON string value decoder - front part
// Accepts text bytes, runs the string decoder and the closing-quote scan,
// and pushes the one to four results of a byte as one bundle.
// ============================================================================
module jsv_front import jsv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jsv_in_if.sink       text,
    input  logic         full,
    output logic         push,
    output bundle_t      bundle
);

    phase_t     phase_reg, phase_next;
    logic       cesc_reg, cesc_next;
    logic [1:0] hcnt_reg, hcnt_next;
    logic [7:0] held_reg [HOLD_MAX];
    logic       held_we;
    logic       accept;
    logic [7:0] c;
    logic       eot;
    bundle_t    bnd;

    assign text.ready = !full;
    assign accept     = text.valid && text.ready;
    assign c          = text.text_byte;
    assign eot        = text.end_of_text;
    assign bundle     = bnd;
    assign push       = accept && (bnd.cnt != 3'd0);

    always_comb
    begin
        phase_next = phase_reg;
        cesc_next  = cesc_reg;
        hcnt_next  = hcnt_reg;
        held_we    = 1'b0;
        bnd        = '0;

        if (phase_reg == PH_WAIT)
        begin
            if (c == CH_QUOTE)
            begin
                cesc_next = 1'b0;
                hcnt_next = 2'd0;
                if (eot)
                begin
                    bnd.ent[0] = mk_res(CH_NUL, KIND_UNTERM, 1'b1);
                    bnd.cnt    = 3'd1;
                end
                else
                begin
                    phase_next = PH_TEXT;
                end
            end
            else if ((c == CH_NUL) || !is_blank(c) || eot)
            begin
                bnd.ent[0] = mk_res(CH_NUL, KIND_NOTSTR, 1'b1);
                bnd.cnt    = 3'd1;
            end
        end
        else if (c == CH_NUL)
        begin
            bnd.ent[0] = mk_res(CH_NUL, KIND_UNTERM, 1'b1);
            bnd.cnt    = 3'd1;
            phase_next = PH_WAIT;
            cesc_next  = 1'b0;
            hcnt_next  = 2'd0;
        end
        else if (!cesc_reg && (c == CH_QUOTE))
        begin
            if (phase_reg == PH_ESC)
            begin
                bnd.ent[bnd.cnt[1:0]] = mk_res(CH_BSLASH, KIND_DATA, 1'b0);
                bnd.cnt = bnd.cnt + 3'd1;
            end
            else if ((phase_reg == PH_HOLD) && (hcnt_reg != 2'd0))
            begin
                // Held characters are decoded as plain text; a trailing
                // backslash stays literal.
                if ((held_reg[0] == CH_BSLASH) && (hcnt_reg > 2'd1))
                begin
                    bnd.ent[bnd.cnt[1:0]] = mk_res(map_escape(held_reg[1]), KIND_DATA, 1'b0);
                    bnd.cnt = bnd.cnt + 3'd1;
                    if (hcnt_reg > 2'd2)
                    begin
                        bnd.ent[bnd.cnt[1:0]] = mk_res(held_reg[2], KIND_DATA, 1'b0);
                        bnd.cnt = bnd.cnt + 3'd1;
                    end
                end
                else
                begin
                    bnd.ent[bnd.cnt[1:0]] = mk_res(held_reg[0], KIND_DATA, 1'b0);
                    bnd.cnt = bnd.cnt + 3'd1;
                    if (hcnt_reg > 2'd1)
                    begin
                        if ((held_reg[1] == CH_BSLASH) && (hcnt_reg > 2'd2))
                        begin
                            bnd.ent[bnd.cnt[1:0]] =
                                mk_res(map_escape(held_reg[2]), KIND_DATA, 1'b0);
                            bnd.cnt = bnd.cnt + 3'd1;
                        end
                        else
                        begin
                            bnd.ent[bnd.cnt[1:0]] = mk_res(held_reg[1], KIND_DATA, 1'b0);
                            bnd.cnt = bnd.cnt + 3'd1;
                            if (hcnt_reg > 2'd2)
                            begin
                                bnd.ent[bnd.cnt[1:0]] =
                                    mk_res(held_reg[2], KIND_DATA, 1'b0);
                                bnd.cnt = bnd.cnt + 3'd1;
                            end
                        end
                    end
                end
            end
            bnd.ent[bnd.cnt[1:0]] = mk_res(CH_NUL, KIND_CLOSED, 1'b1);
            bnd.cnt    = bnd.cnt + 3'd1;
            phase_next = PH_WAIT;
            cesc_next  = 1'b0;
            hcnt_next  = 2'd0;
        end
        else
        begin
            // Closing-quote scan: a backslash skips the next byte.
            if (cesc_reg)
                cesc_next = 1'b0;
            else if (c == CH_BSLASH)
                cesc_next = 1'b1;

            unique case (phase_reg)
                PH_ESC:
                begin
                    bnd.ent[0] = mk_res(map_escape(c), KIND_DATA, 1'b0);
                    bnd.cnt    = 3'd1;
                    hcnt_next  = 2'd0;
                    phase_next = (c == CH_LOW_U) ? PH_HOLD : PH_TEXT;
                end
                PH_HOLD:
                begin
                    if (hcnt_reg >= HOLD_FULL)
                    begin
                        hcnt_next  = 2'd0;
                        phase_next = PH_TEXT;
                    end
                    else
                    begin
                        held_we   = 1'b1;
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
                default:
                begin
                    if (c == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        bnd.ent[0] = mk_res(c, KIND_DATA, 1'b0);
                        bnd.cnt    = 3'd1;
                    end
                end
            endcase

            if (eot)
            begin
                bnd.ent[bnd.cnt[1:0]] = mk_res(CH_NUL, KIND_UNTERM, 1'b1);
                bnd.cnt    = bnd.cnt + 3'd1;
                phase_next = PH_WAIT;
                cesc_next  = 1'b0;
                hcnt_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            cesc_reg  <= 1'b0;
            hcnt_reg  <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cesc_reg  <= cesc_next;
            hcnt_reg  <= hcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && held_we)
            held_reg[hcnt_reg] <= c;
    end

`ifndef ASSERT_OFF
    a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
        (hcnt_reg != 2'd0) |-> (phase_reg == PH_HOLD))
        else $error("held count set outside the hold phase");

    a_wait_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> !cesc_reg)
        else $error("closing scan escape left set between strings");
`endif

endmodule

FILE: hw/rtl/jsv_fifo.sv
// ============================================================================
// JSON string value decoder - bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ============================================================================
module jsv_fifo import jsv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t        mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("bundle queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("bundle queue read while empty");
`endif

endmodule

FILE: hw/rtl/jsv_back.sv
// ============================================================================
// JSON string value decoder - back part
// Walks the head bundle one result at a time into the output register.
// ============================================================================
module jsv_back import jsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  bundle_t   head,
    output logic      pop,
    jsv_out_if.source result
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       fire;
    logic       at_end;

    assign fire   = head_valid && (!out_valid_reg || result.ready);
    assign at_end = ({1'b0, idx_reg} == (head.cnt - 3'd1));
    assign pop    = fire && at_end;

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_reg.out_byte;
    assign result.kind     = out_reg.kind;
    assign result.last     = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (fire)
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= head.ent[idx_reg];
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, idx_reg} < head.cnt))
        else $error("result index beyond the bundle");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind != KIND_DATA)) |-> result.last)
        else $error("closing result without last");
`endif

endmodule

FILE: hw/rtl/json_string_value_decoder.sv
// ============================================================================
// JSON string value decoder - top level
// Decodes one JSON string value from a byte stream into its characters,
// followed by a closing, not-a-string or unterminated result word.
// ============================================================================
//
//   Channel   Dir   Word                                 Accepted when
//   -------   ---   ----------------------------------   -----------------------
//   text      in    text_byte[7:0], end_of_text          text.valid & text.ready
//   result    out   out_byte[7:0], kind[1:0], last        result.valid & result.ready
//
// The front part takes one text byte per cycle; its ready drops only when the
// bundle queue (QUEUE_DEPTH bundles) is full.
// The back part moves one result word per cycle from the queue head into the
// output register, unless the word waiting there has not yet been taken.
// A result word waits in the output register while new bytes are still taken.
// Reset is asynchronous and active low; it returns the decoder to waiting for
// an opening quote and empties the queue and the output register.
//
module json_string_value_decoder import jsv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    jsv_in_if.sink     text,
    jsv_out_if.source  result
);

    // Bundles of results travel from the decoder front through a short queue,
    // so a stalled output does not stop the decoder at once.
    logic    push;
    logic    full;
    logic    pop;
    logic    head_valid;
    bundle_t push_data;
    bundle_t head;

    jsv_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .full   (full),
        .push   (push),
        .bundle (push_data)
    );

    jsv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    jsv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule
